// ===== hdl/cpc_pkg.sv =====
// Package for the copper palette color block: item structs for both channels,
// hue sector codes and the fixed angle constant of the sine table builder.
// Depends on nothing; used by copper_palette_color.
`timescale 1ns / 1ps

package cpc_pkg;

	// Input item: vertical position and animation phase
	typedef struct packed {
		logic [15:0] scan_fraction;
		logic [17:0] anim_phase;
	} cpc_coord_t;

	// Result item: one RGB color, alpha implied full
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} cpc_color_t;

	// Hue sector codes, one per sixth of the color wheel; the last sixth, code 5, has no named constant
	typedef logic [2:0] cpc_sector_t;
	localparam cpc_sector_t SECT_RED_YELLOW   = 3'd0;
	localparam cpc_sector_t SECT_YELLOW_GREEN = 3'd1;
	localparam cpc_sector_t SECT_GREEN_CYAN   = 3'd2;
	localparam cpc_sector_t SECT_CYAN_BLUE    = 3'd3;
	localparam cpc_sector_t SECT_BLUE_MAGENTA = 3'd4;

	// pi/2 in Q2.30, the step base of the quarter-wave table
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

endpackage

// ===== hdl/copper_palette_color.sv =====
// Copper bar palette color generator: sine-driven luminance, drifting hue and
// a six-sector HSV to RGB conversion in a seven-stage pipeline.
// Depends on cpc_pkg for the item structs and sector codes.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                    Payload
// coord     in         coord_valid / coord_stall    cpc_coord_t (scan_fraction, anim_phase)
// color     out        color_valid / color_stall    cpc_color_t (red, green, blue)
//
// An accepted coord item passes through the seven registered stages to its color
// item; one item enters every cycle while coord_stall is low.
// Each stage holds its own valid bit, so bubbles close up while color is stalled
// and coord_stall rises only when every stage is full and the output is stalled.
// Reset clears the valid bits only; there is no other state and no clearing pass.
// The quarter-wave sine table is constant logic built at elaboration.

module copper_palette_color
	import cpc_pkg::*;
#(
	parameter int FRACTION_BITS    = 16,
	parameter int SINE_TABLE_DEPTH = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       coord_valid,
	output logic       coord_stall,
	input  cpc_coord_t coord,
	output logic       color_valid,
	input  logic       color_stall,
	output cpc_color_t color
);

	localparam int F   = FRACTION_BITS;
	localparam int D   = SINE_TABLE_DEPTH;
	localparam int QD  = 4 * D;
	localparam int IW  = $clog2(QD);
	localparam int QDW = $clog2(QD + 1);
	localparam int RW  = $clog2(D + 1);
	localparam int AW  = $clog2(D);

	localparam longint unsigned ONE_L = 64'd1 << F;
	localparam logic [F:0] ONE = (F+1)'(ONE_L);
	localparam logic [F:0] K35 = (F+1)'((35 * ONE_L + 50) / 100);
	localparam logic [F:0] K65 = (F+1)'((65 * ONE_L + 50) / 100);
	localparam logic [F:0] K85 = (F+1)'((85 * ONE_L + 50) / 100);
	localparam logic [F:0] K13 = (F+1)'((13 * ONE_L + 5) / 10);
	localparam logic [F:0] KP  = ONE - K85;

	localparam logic [IW-1:0] D1 = IW'(D);
	localparam logic [IW-1:0] D2 = IW'(2 * D);
	localparam logic [IW-1:0] D3 = IW'(3 * D);

	// Quarter-wave sine entry k, Q0.F, from a truncated Taylor series in Q2.30
	function automatic longint unsigned rom_entry(input longint unsigned k);
		longint unsigned x, x2, term, sum;
		if (k >= SINE_TABLE_DEPTH) begin
			return ONE_L;
		end
		x    = (k * HALF_PI_Q30) / SINE_TABLE_DEPTH;
		x2   = (x * x) >> 30;
		term = ((x * x2) >> 30) / 6;
		sum  = x - term;
		term = ((term * x2) >> 30) / 20;
		sum  = sum + term;
		term = ((term * x2) >> 30) / 42;
		sum  = sum - term;
		term = ((term * x2) >> 30) / 72;
		sum  = sum + term;
		term = ((term * x2) >> 30) / 110;
		sum  = sum - term;
		term = ((term * x2) >> 30) / 156;
		sum  = sum + term;
		sum  = (sum * ONE_L + (64'd1 << 29)) >> 30;
		return (sum > ONE_L) ? ONE_L : sum;
	endfunction

	// Scale a Q0.F fraction to an 8-bit channel, truncating
	function automatic logic [7:0] to_channel(input logic [F:0] x);
		logic [F+8:0] m;
		logic [8:0]   c;
		m = ((F+9)'(x) << 8) - (F+9)'(x);
		c = 9'(m >> F);
		return (c > 9'd255) ? 8'hff : c[7:0];
	endfunction

	// Constant sine table below the peak; the peak itself reads as one
	logic [F:0] sine_rom [0:D-1];
	for (genvar k = 0; k < D; k++) begin : g_rom
		assign sine_rom[k] = (F+1)'(rom_entry(longint'(k)));
	end

	// Stage valid bits and per-stage ready chain
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;

	assign rdy7 = !vld_s7 || !color_stall;
	assign rdy6 = !vld_s6 || rdy7;
	assign rdy5 = !vld_s5 || rdy6;
	assign rdy4 = !vld_s4 || rdy5;
	assign rdy3 = !vld_s3 || rdy4;
	assign rdy2 = !vld_s2 || rdy3;
	assign rdy1 = !vld_s1 || rdy2;

	assign coord_stall = !rdy1;
	assign color_valid = vld_s7;

	// Advance valid bits wherever the next stage has room
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= coord_valid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) vld_s4 <= vld_s3;
			if (rdy5) vld_s5 <= vld_s4;
			if (rdy6) vld_s6 <= vld_s5;
			if (rdy7) vld_s7 <= vld_s6;
		end
	end

	// Stage 1: scale inputs, form sine angle and hue product
	logic [F+15:0] v_w;
	logic [F+17:0] ph_w;
	logic [F-1:0]  v, v7, ang;
	logic [F+1:0]  ph;
	logic [2*F:0]  kv;

	always_comb begin
		v_w  = ((F+16)'(coord.scan_fraction) << F) >> 16;
		ph_w = ((F+18)'(coord.anim_phase) << F) >> 16;
		v    = v_w[F-1:0];
		ph   = ph_w[F+1:0];
		v7   = (v << 3) - v;
		ang  = v7 - ph[F-1:0];
		kv   = (2*F+1)'(K13) * (2*F+1)'(v);
	end

	logic [F-1:0] ang_s1, ph4_s1;
	logic [2*F:0] kv_s1;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			ang_s1 <= ang;
			kv_s1  <= kv;
			ph4_s1 <= ph[F+1:2];
		end
	end

	// Stage 2: table index from the angle, hue modulo one
	logic [F+QDW-1:0] aprod;
	logic [F:0]       hsum;

	always_comb begin
		aprod = (F+QDW)'(ang_s1) * (F+QDW)'(QD);
		hsum  = kv_s1[2*F:F] + (F+1)'(ph4_s1);
	end

	logic [IW-1:0] idx_s2;
	logic [F-1:0]  hue_s2;

	always_ff @(posedge clk) begin
		if (rdy2) begin
			idx_s2 <= IW'(aprod >> F);
			hue_s2 <= hsum[F-1:0];
		end
	end

	// Stage 3: quadrant split, mirrored table read, hue sector
	logic [1:0]    quad;
	logic [IW-1:0] base;
	logic [RW-1:0] rr_idx, addr;
	logic [F+2:0]  h6;

	always_comb begin
		if (idx_s2 >= D3) begin
			quad = 2'd3;
			base = D3;
		end else if (idx_s2 >= D2) begin
			quad = 2'd2;
			base = D2;
		end else if (idx_s2 >= D1) begin
			quad = 2'd1;
			base = D1;
		end else begin
			quad = 2'd0;
			base = '0;
		end
		rr_idx = RW'(idx_s2 - base);
		addr   = quad[0] ? (RW'(D) - rr_idx) : rr_idx;
		h6     = ((F+3)'(hue_s2) << 2) + ((F+3)'(hue_s2) << 1);
	end

	logic [F:0]   mag_s3;
	logic         neg_s3;
	cpc_sector_t  sector_s3;
	logic [F-1:0] f_s3;

	always_ff @(posedge clk) begin
		if (rdy3) begin
			mag_s3    <= (addr == RW'(D)) ? ONE : sine_rom[AW'(addr)];
			neg_s3    <= quad[1];
			sector_s3 <= h6[F+2:F];
			f_s3      <= h6[F-1:0];
		end
	end

	// Stage 4: half-wave offset and the three scaling products
	logic [F+1:0]   bsum;
	logic [F:0]     half, nf;
	logic [2*F+1:0] lprod, fk, gk;

	always_comb begin
		bsum  = neg_s3 ? ((F+2)'(ONE) - (F+2)'(mag_s3)) : ((F+2)'(ONE) + (F+2)'(mag_s3));
		half  = bsum[F+1:1];
		nf    = ONE - (F+1)'(f_s3);
		lprod = (2*F+2)'(K65) * (2*F+2)'(half);
		fk    = (2*F+2)'(f_s3) * (2*F+2)'(K85);
		gk    = (2*F+2)'(nf) * (2*F+2)'(K85);
	end

	logic [2*F+1:0] lprod_s4, fk_s4, gk_s4;
	cpc_sector_t    sector_s4;

	always_ff @(posedge clk) begin
		if (rdy4) begin
			lprod_s4  <= lprod;
			fk_s4     <= fk;
			gk_s4     <= gk;
			sector_s4 <= sector_s3;
		end
	end

	// Stage 5: luminance with saturation, complements for q and t
	logic [F+2:0] lsum;
	logic [F:0]   lum, qf, tf;

	always_comb begin
		lsum = (F+3)'(K35) + (F+3)'(lprod_s4 >> F);
		lum  = (lsum > (F+3)'(ONE)) ? ONE : lsum[F:0];
		qf   = ONE - (F+1)'(fk_s4 >> F);
		tf   = ONE - (F+1)'(gk_s4 >> F);
	end

	logic [F:0]  lum_s5, qf_s5, tf_s5;
	cpc_sector_t sector_s5;

	always_ff @(posedge clk) begin
		if (rdy5) begin
			lum_s5    <= lum;
			qf_s5     <= qf;
			tf_s5     <= tf;
			sector_s5 <= sector_s4;
		end
	end

	// Stage 6: p, q and t from the luminance
	logic [2*F+1:0] pprod, qprod, tprod;

	always_comb begin
		pprod = (2*F+2)'(lum_s5) * (2*F+2)'(KP);
		qprod = (2*F+2)'(lum_s5) * (2*F+2)'(qf_s5);
		tprod = (2*F+2)'(lum_s5) * (2*F+2)'(tf_s5);
	end

	logic [F:0]  lum_s6, p_s6, q_s6, t_s6;
	cpc_sector_t sector_s6;

	always_ff @(posedge clk) begin
		if (rdy6) begin
			lum_s6    <= lum_s5;
			p_s6      <= (F+1)'(pprod >> F);
			q_s6      <= (F+1)'(qprod >> F);
			t_s6      <= (F+1)'(tprod >> F);
			sector_s6 <= sector_s5;
		end
	end

	// Stage 7: pick channels by sector and scale to 8 bits
	logic [F:0] r_x, g_x, b_x;

	always_comb begin
		case (sector_s6)
			SECT_RED_YELLOW: begin
				r_x = lum_s6; g_x = t_s6;   b_x = p_s6;
			end
			SECT_YELLOW_GREEN: begin
				r_x = q_s6;   g_x = lum_s6; b_x = p_s6;
			end
			SECT_GREEN_CYAN: begin
				r_x = p_s6;   g_x = lum_s6; b_x = t_s6;
			end
			SECT_CYAN_BLUE: begin
				r_x = p_s6;   g_x = q_s6;   b_x = lum_s6;
			end
			SECT_BLUE_MAGENTA: begin
				r_x = t_s6;   g_x = p_s6;   b_x = lum_s6;
			end
			default: begin
				r_x = lum_s6; g_x = p_s6;   b_x = q_s6;
			end
		endcase
	end

	cpc_color_t color_s7;

	always_ff @(posedge clk) begin
		if (rdy7) begin
			color_s7.red   <= to_channel(r_x);
			color_s7.green <= to_channel(g_x);
			color_s7.blue  <= to_channel(b_x);
		end
	end

	assign color = color_s7;

`ifndef SYNTHESIS
	// Input stalls only when the whole pipeline is full behind a stalled output
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		coord_stall |-> (color_valid && color_stall && vld_s1 && vld_s6))
		else $error("coord stalled while the pipeline has room");

	// A finished stage six item reaches the output when it is free
	a_s6_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s6 && !color_stall) |=> color_valid)
		else $error("stage six item was dropped");

	// Table magnitude never exceeds one
	a_mag_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> (mag_s3 <= ONE))
		else $error("sine magnitude above one");

	// Hue sector stays within the six sixths
	a_sector_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> (sector_s3 <= SECT_BLUE_MAGENTA + 3'd1))
		else $error("hue sector out of range");

	// Luminance saturates at one
	a_lum_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s5 |-> (lum_s5 <= ONE))
		else $error("luminance above one");
`endif

endmodule

// ===== tb/tb_copper_palette_color.sv =====
// Self-checking testbench for copper_palette_color: a directed table, then random items
// paced in four idle/stall phases and a long hold; colors checked vs predictor or table.
// Depends on cpc_pkg and the copper_palette_color RTL.
`timescale 1ns / 1ps

module tb_copper_palette_color;
	import cpc_pkg::*;

	localparam int              FX    = 16;
	localparam longint unsigned DEPTH = 256;
	localparam longint unsigned ONE   = 64'd1 << FX;
	localparam longint unsigned FMASK = ONE - 1;
	localparam longint unsigned K35   = (35 * ONE + 50) / 100;
	localparam longint unsigned K65   = (65 * ONE + 50) / 100;
	localparam longint unsigned K85   = (85 * ONE + 50) / 100;
	localparam longint unsigned K13   = (13 * ONE + 5) / 10;
	localparam int              RANDOM_PER_PHASE = 340;
	localparam int              HOLD_ITEMS       = 40;

	// Directed row: coordinates, plus a hand-computed color where known is set
	typedef struct {
		logic [15:0] sf;
		logic [17:0] ph;
		bit          known;
		cpc_color_t  want;
	} coord_row_t;

	localparam int N_ROWS = 19;
	coord_row_t directed_rows [N_ROWS] = '{
		'{16'd0,     18'd0,      1'b1, '{8'd172, 8'd25,  8'd25}},  // mid luminance, hue zero
		'{16'd0,     18'd49152,  1'b1, '{8'd227, 8'd255, 8'd38}},  // luminance saturates at one
		'{16'd0,     18'd16384,  1'b1, '{8'd89,  8'd41,  8'd13}},  // luminance floor
		'{16'd65535, 18'd0,      1'b0, '{8'd0,   8'd0,   8'd0}},
		'{16'd0,     18'd262143, 1'b0, '{8'd0,   8'd0,   8'd0}},   // phase wraps by width
		'{16'd65535, 18'd262143, 1'b0, '{8'd0,   8'd0,   8'd0}},
		'{16'd32768, 18'd131072, 1'b0, '{8'd0,   8'd0,   8'd0}},
		'{16'd0,     18'd21845,  1'b0, '{8'd0,   8'd0,   8'd0}},   // hue sectors 0..5
		'{16'd0,     18'd65536,  1'b0, '{8'd0,   8'd0,   8'd0}},
		'{16'd0,     18'd109227, 1'b0, '{8'd0,   8'd0,   8'd0}},
		'{16'd0,     18'd152917, 1'b0, '{8'd0,   8'd0,   8'd0}},
		'{16'd0,     18'd196608, 1'b0, '{8'd0,   8'd0,   8'd0}},
		'{16'd0,     18'd240299, 1'b0, '{8'd0,   8'd0,   8'd0}},
		'{16'd65535, 18'd65535,  1'b0, '{8'd0,   8'd0,   8'd0}},
		'{16'd1,     18'd1,      1'b0, '{8'd0,   8'd0,   8'd0}},
		'{16'd43690, 18'd174762, 1'b0, '{8'd0,   8'd0,   8'd0}},
		'{16'd21845, 18'd87381,  1'b0, '{8'd0,   8'd0,   8'd0}},
		'{16'd9362,  18'd0,      1'b0, '{8'd0,   8'd0,   8'd0}},   // sine angle near wrap
		'{16'd0,     18'd65535,  1'b0, '{8'd0,   8'd0,   8'd0}}
	};

	logic       clk;
	logic       arst_n;
	logic       coord_valid;
	logic       coord_stall;
	cpc_coord_t coord;
	logic       color_valid;
	logic       color_stall;
	cpc_color_t color;

	// Side data that travels with the offered item
	bit         coord_known;
	cpc_color_t coord_want;

	cpc_color_t color_expect_q [$];
	int         send_idle_pct;
	int         recv_stall_pct;
	int         hold_request;
	int         coords_accepted;
	int         colors_checked;
	int         mismatch_count;

	copper_palette_color i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.coord_valid (coord_valid),
		.coord_stall (coord_stall),
		.coord       (coord),
		.color_valid (color_valid),
		.color_stall (color_stall),
		.color       (color)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Quarter-wave sine sample k in Q0.16, from a truncating Q2.30 Taylor series
	function automatic longint unsigned quarter_sine(longint unsigned k);
		longint unsigned x, x2, term, acc;
		int n;
		if (k >= DEPTH)
			return ONE;
		x = (k * HALF_PI_Q30) / DEPTH;
		x2 = (x * x) >> 30;
		term = x;
		acc = x;
		for (n = 1; n <= 6; n++) begin
			term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
			if (n % 2)
				acc -= term;
			else
				acc += term;
		end
		acc = (acc * ONE + (64'd1 << 29)) >> 30;
		return (acc > ONE) ? ONE : acc;
	endfunction

	function automatic logic [7:0] to_chan8(longint unsigned x);
		longint unsigned c;
		c = (x * 255) >> FX;
		return (c > 255) ? 8'd255 : c[7:0];
	endfunction

	// Compute the copper color for one coordinate item
	function automatic cpc_color_t predict_color(cpc_coord_t c);
		longint unsigned v, ph, ang, idx, r, mag, half, lum, hue, h6, f, p, q, t;
		longint unsigned rr, gg, bb;
		logic [1:0]  quad;
		cpc_sector_t sect;
		cpc_color_t  res;
		v = (64'(c.scan_fraction) * ONE) >> 16;
		ph = (64'(c.anim_phase) * ONE) >> 16;

		// luminance from the sine of 7v - phase
		ang = (7 * v + 4 * ONE - ph) & FMASK;
		idx = (ang * 4 * DEPTH) >> FX;
		quad = 2'((idx / DEPTH) & 3);
		r = idx % DEPTH;
		mag = quad[0] ? quarter_sine(DEPTH - r) : quarter_sine(r);
		half = quad[1] ? ((ONE - mag) >> 1) : ((ONE + mag) >> 1);
		lum = K35 + ((K65 * half) >> FX);
		if (lum > ONE)
			lum = ONE;

		// drifting hue, then six-sector HSV to RGB
		hue = (((K13 * v) >> FX) + (ph >> 2)) & FMASK;
		h6 = hue * 6;
		f = h6 & FMASK;
		p = (lum * (ONE - K85)) >> FX;
		q = (lum * (ONE - ((f * K85) >> FX))) >> FX;
		t = (lum * (ONE - (((ONE - f) * K85) >> FX))) >> FX;
		sect = cpc_sector_t'(h6 >> FX);
		case (sect)
			SECT_RED_YELLOW: begin
				rr = lum; gg = t; bb = p;
			end
			SECT_YELLOW_GREEN: begin
				rr = q; gg = lum; bb = p;
			end
			SECT_GREEN_CYAN: begin
				rr = p; gg = lum; bb = t;
			end
			SECT_CYAN_BLUE: begin
				rr = p; gg = q; bb = lum;
			end
			SECT_BLUE_MAGENTA: begin
				rr = t; gg = p; bb = lum;
			end
			default: begin
				rr = lum; gg = p; bb = q;
			end
		endcase
		res.red = to_chan8(rr);
		res.green = to_chan8(gg);
		res.blue = to_chan8(bb);
		return res;
	endfunction

	// Random coordinates, leaning on the field extremes now and then
	function automatic cpc_coord_t rand_coord();
		cpc_coord_t c;
		c.scan_fraction = 16'($urandom);
		c.anim_phase = 18'($urandom);
		if ($urandom_range(9) < 2)
			c.scan_fraction = $urandom_range(1) ? 16'hFFFF : 16'h0000;
		if ($urandom_range(9) < 2)
			c.anim_phase = $urandom_range(1) ? 18'h3FFFF : 18'h00000;
		return c;
	endfunction

	// Offer one item from a falling edge; return at the falling edge after acceptance
	task automatic offer_coord(input cpc_coord_t c, input bit known, input cpc_color_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			coord_valid <= 1'b0;
			@(negedge clk);
		end
		coord_valid <= 1'b1;
		coord <= c;
		coord_known <= known;
		coord_want <= want;
		@(posedge clk);
		while (coord_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_colors_drained();
		while (color_expect_q.size() != 0)
			@(negedge clk);
	endtask

	// Record accepted coordinates and check accepted colors
	always @(posedge clk) begin
		cpc_color_t want;
		if (arst_n && coord_valid && !coord_stall) begin
			color_expect_q.insert(color_expect_q.size(),
				coord_known ? coord_want : predict_color(coord));
			coords_accepted++;
		end
		if (arst_n && color_valid && !color_stall) begin
			if (color_expect_q.size() == 0) begin
				$error("color item with no coordinate pending: %0d %0d %0d",
					color.red, color.green, color.blue);
				mismatch_count++;
			end else begin
				want = color_expect_q.pop_front();
				colors_checked++;
				if (color.red !== want.red) begin
					$error("red: expected %0d, actual %0d", want.red, color.red);
					mismatch_count++;
				end
				if (color.green !== want.green) begin
					$error("green: expected %0d, actual %0d", want.green, color.green);
					mismatch_count++;
				end
				if (color.blue !== want.blue) begin
					$error("blue: expected %0d, actual %0d", want.blue, color.blue);
					mismatch_count++;
				end
			end
		end
	end

	// Drive color_stall: a requested hold-off first, else random stalls
	initial begin
		int hold_left;
		hold_left = 0;
		color_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				color_stall <= 1'b1;
				hold_left--;
			end else begin
				color_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// Bound the run
	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

	// Main sequence
	initial begin
		int send_pcts [4];
		int stall_pcts [4];
		cpc_coord_t c;
		cpc_color_t none;
		send_pcts = '{0, 80, 0, 28};
		stall_pcts = '{0, 0, 80, 28};
		none = '0;
		arst_n = 1'b0;
		coord_valid = 1'b0;
		coord = '0;
		coord_known = 1'b0;
		coord_want = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_request = 0;
		coords_accepted = 0;
		colors_checked = 0;
		mismatch_count = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// walk the directed table
		foreach (directed_rows[i]) begin
			c.scan_fraction = directed_rows[i].sf;
			c.anim_phase = directed_rows[i].ph;
			offer_coord(c, directed_rows[i].known, directed_rows[i].want);
		end
		coord_valid <= 1'b0;
		@(negedge clk);
		wait_colors_drained();

		// random items in each pacing phase; drain before changing pace
		for (int ph_i = 0; ph_i < 4; ph_i++) begin
			send_idle_pct = send_pcts[ph_i];
			recv_stall_pct = stall_pcts[ph_i];
			repeat (RANDOM_PER_PHASE)
				offer_coord(rand_coord(), 1'b0, none);
			coord_valid <= 1'b0;
			@(negedge clk);
			wait_colors_drained();
		end

		// hold the output off for a long stretch while items keep coming
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_request = 80;
		repeat (HOLD_ITEMS)
			offer_coord(rand_coord(), 1'b0, none);
		coord_valid <= 1'b0;
		@(negedge clk);
		wait_colors_drained();

		// let any stray color item show up
		repeat (20) @(negedge clk);
		$display("Ran %0d coordinate items (directed table, random, long output hold),",
			coords_accepted);
		$display("checked %0d color items under four idle/stall mixes.", colors_checked);
		if (mismatch_count == 0 && color_expect_q.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
